// ===== sv/crr_pkg.sv =====
// Shared types and constants for the cyclic rotation representative block.
// No dependencies; used by crr_cell and cyclic_rotation_representative.
package crr_pkg;

  localparam int MAX_SITES = 32;
  localparam int STATE_W   = 32;
  // Largest usable ring: bounded by MAX_SITES and by the state width.
  localparam int RING_LIM  = (MAX_SITES < STATE_W) ? MAX_SITES : STATE_W;
  localparam int SITES_W   = 6;
  localparam int DIST_W    = 5;
  localparam int PADDR_W   = 2;

  localparam logic [PADDR_W-1:0] ADDR_RING_SITES = 2'd0;
  localparam logic [SITES_W-1:0] RING_SITES_RST  = 6'd16;

  // Partial result carried from cell to cell.
  typedef struct packed {
    logic [STATE_W-1:0] x;        // masked input state
    logic [STATE_W-1:0] cur;      // current rotation
    logic [STATE_W-1:0] rep;      // smallest rotation so far
    logic [DIST_W-1:0]  rot_dist; // rotation count of rep
    logic [SITES_W-1:0] period;   // orbit period (ring size until found)
    logic               found;    // period already found
  } stage_t;

endpackage

// ===== sv/crr_cell.sv =====
// One cell of the rotation chain: within the ring size, applies one left
// rotation and updates the running minimum and period. Depends on crr_pkg.
module crr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [crr_pkg::SITES_W-1:0]   idx_i,   // rotation count of this cell
  input  logic [crr_pkg::SITES_W-1:0]   n_i,     // effective ring size
  input  logic [crr_pkg::STATE_W-1:0]   mask_i,
  input  logic                          valid_i,
  input  crr_pkg::stage_t               data_i,
  output logic                          ready_o,
  output logic                          valid_o,
  output crr_pkg::stage_t               data_o,
  input  logic                          ready_i
);

  logic                        valid_q;
  crr_pkg::stage_t             data_q, data_d;
  logic [crr_pkg::STATE_W-1:0] rot;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rot = ((data_i.cur << 1) | (data_i.cur >> (n_i - 6'd1))) & mask_i;
    data_d = data_i;
    if (idx_i <= n_i) begin
      data_d.cur = rot;
      if ((idx_i < n_i) && (rot < data_i.rep)) begin
        data_d.rep      = rot;
        data_d.rot_dist = idx_i[crr_pkg::DIST_W-1:0];
      end
      if (!data_i.found && (rot == data_i.x)) begin
        data_d.period = idx_i;
        data_d.found  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/cyclic_rotation_representative.sv =====
// Cyclic rotation representative: minimum rotation, its distance and the
// orbit period of a ring of state bits. Depends on crr_pkg and crr_cell.
// An accepted request passes through all RING_LIM cells, each registered, to the result.
// Throughput: one request per cycle while the result is not stalled; each cell holds
// its own request and lets bubbles collapse, so a stalled result stops only the cells behind it.
// Reset: all cell valid bits clear, ring_sites returns to 16.
module cyclic_rotation_representative (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB-style configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [crr_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [crr_pkg::STATE_W-1:0]       basis_state_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [crr_pkg::STATE_W-1:0]       representative_o,
  output logic [crr_pkg::DIST_W-1:0]        rotation_distance_o,
  output logic [crr_pkg::SITES_W-1:0]       orbit_period_o
);

  localparam int L = crr_pkg::RING_LIM;

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [crr_pkg::SITES_W-1:0] ring_sites_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_sites_q <= crr_pkg::RING_SITES_RST;
    end else if (psel && penable && pwrite && (paddr == crr_pkg::ADDR_RING_SITES)) begin
      ring_sites_q <= pwdata[crr_pkg::SITES_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == crr_pkg::ADDR_RING_SITES)
                  ? {{(32-crr_pkg::SITES_W){1'b0}}, ring_sites_q} : 32'd0;

  // ---------------------------------------------------------------
  // Effective ring size and mask. Zero acts as a one-bit ring; large
  // values saturate at RING_LIM. The user must change config only
  // while idle (not enforced by the block); cells share these directly.
  // ---------------------------------------------------------------
  logic [crr_pkg::SITES_W-1:0] n_eff;
  logic [crr_pkg::STATE_W-1:0] mask;

  always_comb begin
    priority if (ring_sites_q == '0) begin
      n_eff = crr_pkg::SITES_W'(1);
    end else if (ring_sites_q > crr_pkg::SITES_W'(L)) begin
      n_eff = crr_pkg::SITES_W'(L);
    end else begin
      n_eff = ring_sites_q;
    end
  end

  assign mask = {crr_pkg::STATE_W{1'b1}} >> (crr_pkg::SITES_W'(crr_pkg::STATE_W) - n_eff);

  // ---------------------------------------------------------------
  // Entry: rotation zero is the masked state itself.
  // ---------------------------------------------------------------
  crr_pkg::stage_t entry;

  always_comb begin
    entry.x        = basis_state_i & mask;
    entry.cur      = basis_state_i & mask;
    entry.rep      = basis_state_i & mask;
    entry.rot_dist = '0;
    entry.period   = n_eff;
    entry.found    = 1'b0;
  end

  // ---------------------------------------------------------------
  // Chain of cells; cell k applies rotation k+1. The last cell's
  // register doubles as the output register.
  // ---------------------------------------------------------------
  logic            valid_c [L+1];
  logic            ready_c [L+1];
  crr_pkg::stage_t data_c  [L+1];

  assign valid_c[0] = in_valid_i;
  assign data_c[0]  = entry;
  assign in_stall_o = !ready_c[0];
  assign ready_c[L] = !out_stall_i;

  for (genvar k = 0; k < L; k++) begin : g_cell
    crr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (crr_pkg::SITES_W'(k + 1)),
      .n_i     (n_eff),
      .mask_i  (mask),
      .valid_i (valid_c[k]),
      .data_i  (data_c[k]),
      .ready_o (ready_c[k]),
      .valid_o (valid_c[k+1]),
      .data_o  (data_c[k+1]),
      .ready_i (ready_c[k+1])
    );
  end

  assign out_valid_o         = valid_c[L];
  assign representative_o    = data_c[L].rep;
  assign rotation_distance_o = data_c[L].rot_dist;
  assign orbit_period_o      = data_c[L].period;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  logic any_valid;
  always_comb begin
    any_valid = 1'b0;
    for (int j = 1; j <= L; j++) begin
      any_valid = any_valid | valid_c[j];
    end
  end

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_valid |-> !in_stall_o)
    else $error("chain empty but request stalled");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (orbit_period_o != '0) && (orbit_period_o <= n_eff))
    else $error("orbit period out of range");

  a_dist_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, rotation_distance_o} < orbit_period_o))
    else $error("rotation distance not below period");

  a_rep_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((representative_o & ~mask) == '0))
    else $error("representative has bits outside the ring");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for cyclic_rotation_representative: ring-size sweep,
// directed edge states, then random basis states under random idling.
// Depends on crr_pkg and the cyclic_rotation_representative RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 12;   // ring-size settings visited
  localparam int RAND_PER_PHASE  = 90;   // random requests per setting
  localparam int WATCHDOG_LIMIT  = 4000; // cycles without any handshake
  localparam int HOLD_CYCLES     = 200;  // long output hold-off, > pipeline depth
  // Addresses with no register behind them; writes there must be dropped.
  localparam logic [crr_pkg::PADDR_W-1:0] ADDR_UNMAPPED_LO = 2'd1;
  localparam logic [crr_pkg::PADDR_W-1:0] ADDR_UNMAPPED_HI = 2'd3;

  // Expected result of one request.
  typedef struct packed {
    logic [crr_pkg::STATE_W-1:0] rep;
    logic [crr_pkg::DIST_W-1:0]  rot_dist;
    logic [crr_pkg::SITES_W-1:0] period;
  } orbit_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [crr_pkg::PADDR_W-1:0] paddr         = '0;
  logic [31:0]                 pwdata        = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [crr_pkg::STATE_W-1:0] basis_state_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [crr_pkg::STATE_W-1:0] representative_o;
  logic [crr_pkg::DIST_W-1:0]  rotation_distance_o;
  logic [crr_pkg::SITES_W-1:0] orbit_period_o;

  cyclic_rotation_representative dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .basis_state_i       (basis_state_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .representative_o    (representative_o),
    .rotation_distance_o (rotation_distance_o),
    .orbit_period_o      (orbit_period_o)
  );

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  logic [crr_pkg::STATE_W-1:0] basis_queue[$];    // states waiting to be offered
  orbit_t                      pending_orbits[$]; // predicted results, oldest first
  logic [crr_pkg::SITES_W-1:0] ring_cfg = crr_pkg::RING_SITES_RST; // copy of ring_sites
  int errors         = 0;
  int results_seen   = 0;
  int requests_sent  = 0;
  int stalled_cycles = 0;
  int quiet_cycles   = 0;

  // sender / receiver private idling state
  int  send_gap         = 0;
  int  send_calm_left   = 0;
  int  recv_stall_left  = 0;
  int  recv_calm_left   = 0;
  int  hold_left        = 0;
  bit  hold_done        = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Effective ring length: 0 behaves as 1, anything past RING_LIM saturates.
  function automatic int ring_len(input logic [crr_pkg::SITES_W-1:0] sites);
    int n;
    n = int'(sites);
    if (n < 1) n = 1;
    if (n > crr_pkg::RING_LIM) n = crr_pkg::RING_LIM;
    return n;
  endfunction

  // Smallest rotation, first rotation count reaching it, and orbit period.
  function automatic orbit_t min_rotation(input logic [crr_pkg::STATE_W-1:0] state,
                                          input logic [crr_pkg::SITES_W-1:0] sites);
    int          n;
    logic [63:0] mask, x, cur;
    orbit_t      o;
    bit          found;
    n          = ring_len(sites);
    mask       = (64'd1 << n) - 64'd1;
    x          = {32'd0, state} & mask;
    cur        = x;
    o.rep      = x[crr_pkg::STATE_W-1:0];
    o.rot_dist = '0;
    o.period   = crr_pkg::SITES_W'(n);
    found      = 1'b0;
    for (int i = 1; i <= n; i++) begin
      cur = ((cur << 1) | (cur >> (n - 1))) & mask;
      // strict compare keeps the earliest count on ties
      if (i < n && cur[crr_pkg::STATE_W-1:0] < o.rep) begin
        o.rep      = cur[crr_pkg::STATE_W-1:0];
        o.rot_dist = crr_pkg::DIST_W'(i);
      end
      if (!found && cur == x) begin
        o.period = crr_pkg::SITES_W'(i);
        found    = 1'b1;
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Append one state to the list of pending requests.
  function automatic void add_basis(input logic [crr_pkg::STATE_W-1:0] v);
    basis_queue.insert(basis_queue.size(), v);
  endfunction

  // Idle length: mostly none, some short, a few long; none at all when calm.
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random state shaped for the ring: uniform, periodic (to hit short orbits
  // and ties), sparse/dense, or an all-zero / all-one ring with junk above.
  function automatic logic [crr_pkg::STATE_W-1:0] random_basis(input int n);
    logic [crr_pkg::STATE_W-1:0] v, pat, mask;
    int p, kind;
    v    = $urandom;
    mask = (n >= crr_pkg::STATE_W) ? '1 : ((32'd1 << n) - 32'd1);
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      p = $urandom_range(1, n);
      while (n % p != 0) p = $urandom_range(1, n);
      pat = $urandom;
      for (int i = 0; i < n; i++) v[i] = pat[i % p];
    end else if (kind < 5) begin
      v = $urandom & $urandom & $urandom;
      if ($urandom_range(0, 1)) v = ~v;
    end else if (kind == 5) begin
      v = $urandom_range(0, 1) ? (v | mask) : (v & ~mask);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Request driver: feeds basis_queue onto the input channel. The payload is
  // held while stalled; gaps are inserted only after a request is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_stall_o) stalled_cycles++;
      // request taken at this edge: predict with the current ring setting
      if (in_valid_i && !in_stall_o) begin
        pending_orbits.insert(pending_orbits.size(), min_rotation(basis_state_i, ring_cfg));
        requests_sent++;
      end
      // occasional stretches with back-to-back requests
      if (send_calm_left > 0) send_calm_left--;
      else if ($urandom_range(0, 149) == 0) send_calm_left = $urandom_range(40, 200);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (basis_queue.size() > 0) begin
          in_valid_i    <= 1'b1;
          basis_state_i <= basis_queue.pop_front();
          send_gap = idle_len(send_calm_left > 0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each taken result against the oldest prediction
  // and drives out_stall_i, including one long hold-off that backs the
  // pipeline up into the input channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    orbit_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_orbits.size() == 0) begin
        errors++;
        $display("[%0t] unexpected result: representative %h", $time, representative_o);
      end else begin
        want = pending_orbits.pop_front();
        if (representative_o !== want.rep) begin
          errors++;
          $display("[%0t] representative mismatch: expected %h, got %h",
                   $time, want.rep, representative_o);
        end
        if (rotation_distance_o !== want.rot_dist) begin
          errors++;
          $display("[%0t] rotation_distance mismatch: expected %0d, got %0d",
                   $time, want.rot_dist, rotation_distance_o);
        end
        if (orbit_period_o !== want.period) begin
          errors++;
          $display("[%0t] orbit_period mismatch: expected %0d, got %0d",
                   $time, want.period, orbit_period_o);
        end
      end
    end

    if (recv_calm_left > 0) recv_calm_left--;
    else if ($urandom_range(0, 149) == 0) recv_calm_left = $urandom_range(40, 200);

    // one long hold-off while plenty of requests are still queued
    if (!hold_done && results_seen > 200 && basis_queue.size() > 60) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end

    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (recv_stall_left > 0) begin
      out_stall_i <= 1'b1;
      recv_stall_left--;
    end else begin
      recv_stall_left = idle_len(recv_calm_left > 0);
      out_stall_i <= (recv_stall_left > 0);
      if (recv_stall_left > 0) recv_stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on either channel or the config port keeps it quiet
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("cyclic_rotation_representative test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Config port access (setup + access phase)
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [crr_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // only the ring_sites address holds a register; the rest drop the write
    if (addr == crr_pkg::ADDR_RING_SITES) ring_cfg = data[crr_pkg::SITES_W-1:0];
  endtask

  task automatic cfg_read_check();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= crr_pkg::ADDR_RING_SITES;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[crr_pkg::SITES_W-1:0] !== ring_cfg) begin
      errors++;
      $display("[%0t] ring_sites readback mismatch: expected %0d, got %0d",
               $time, ring_cfg, prdata[crr_pkg::SITES_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block is idle once everything queued has gone in and come back out.
  task automatic wait_drained();
    while (basis_queue.size() != 0 || in_valid_i || pending_orbits.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: from phase 1 on set ring_sites while idle, queue directed
  // states for the interesting settings, then a batch of random states.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [crr_pkg::SITES_W-1:0] sweep [NUM_PHASES];
    // reset value, zero (acts as one), single bit, two bits, full width,
    // max field value and just past full width (both saturate), odd sizes
    sweep = '{6'd16, 6'd0, 6'd1, 6'd2, 6'd32, 6'd63, 6'd33, 6'd3, 6'd7, 6'd31,
              6'd16, 6'd16};
    sweep[10] = crr_pkg::SITES_W'($urandom_range(1, 63));
    sweep[11] = crr_pkg::SITES_W'($urandom_range(1, 63));

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      repeat (crr_pkg::RING_LIM + 4) @(posedge clk_i);
      // phase 0 runs on the reset value; upper pwdata bits are junk
      if (ph > 0) begin
        cfg_write(crr_pkg::ADDR_RING_SITES,
                  ($urandom << crr_pkg::SITES_W) | 32'(sweep[ph]));
      end
      if (ph == 3) begin
        cfg_write(ADDR_UNMAPPED_LO, $urandom);
        cfg_write(ADDR_UNMAPPED_HI, $urandom);
      end
      cfg_read_check();

      case (ph)
        0: begin
          // 16-bit ring: extremes, junk above the ring, ties, periodic
          add_basis(32'h0000_0000); add_basis(32'hFFFF_FFFF);
          add_basis(32'h0000_FFFF); add_basis(32'hFFFF_0000);
          add_basis(32'h0000_0001); add_basis(32'h0000_8000);
          add_basis(32'h0000_5555); add_basis(32'h0000_AAAA);
          add_basis(32'h0000_1111); add_basis(32'h1234_5678);
          add_basis(32'h0000_C000);
        end
        1: begin
          add_basis(32'hFFFF_FFFF); add_basis(32'hFFFF_FFFE);
        end
        2: begin
          add_basis(32'h0000_0001); add_basis(32'h0000_0000);
        end
        4: begin
          // full 32-bit ring
          add_basis(32'hFFFF_FFFF); add_basis(32'h8000_0000);
          add_basis(32'h5555_5555); add_basis(32'h0000_0001);
          add_basis(32'h7FFF_FFFF);
        end
        5: add_basis(32'h8000_0001);
        default: ;
      endcase

      for (int k = 0; k < RAND_PER_PHASE; k++)
        add_basis(random_basis(ring_len(ring_cfg)));
    end

    wait_drained();
    repeat (crr_pkg::RING_LIM + 8) @(posedge clk_i);

    $display("Run covered %0d requests, %0d results, over %0d ring_sites settings",
             requests_sent, results_seen, NUM_PHASES);
    $display("incl. zero/one/saturated rings and %0d cycles of input backpressure",
             stalled_cycles);
    if (errors == 0) begin
      $display("cyclic_rotation_representative test passed");
    end else begin
      $display("%0d errors", errors);
      $display("cyclic_rotation_representative test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/crr_pkg.sv
sv/crr_cell.sv
sv/cyclic_rotation_representative.sv
test/tb_top.sv
